@@ rtl/core/lmrsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix row scan driver package
// Panel geometry, store sizing, function codes and controller states.
// ----------------------------------------------------------------------------
package lmrsd_pkg;

    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 32;

    // Each memory holds one half of the panel, so a shift reads both at once.
    localparam int HALF_HEIGHT = PANEL_HEIGHT / 2;
    localparam int HALF_DEPTH  = PANEL_WIDTH * HALF_HEIGHT;
    localparam int ADDR_W      = $clog2(HALF_DEPTH);
    localparam int COL_W       = $clog2(PANEL_WIDTH);

    // The address lines A to D limit the scan to sixteen rows.
    localparam int ROW_W   = 4;
    localparam int ROW_MAX = 15;

    localparam logic [2:0] BIT_RED   = 3'b001;
    localparam logic [2:0] BIT_GREEN = 3'b010;
    localparam logic [2:0] BIT_BLUE  = 3'b100;

    typedef enum logic [1:0] {
        FN_WRITE   = 2'd0,
        FN_FILL    = 2'd1,
        FN_REFRESH = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_SCAN
    } state_t;

    // Nonzero level turns the channel on.
    function automatic logic [2:0] color_bits(input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b);
        logic [2:0] c;
        c = 3'b000;
        if (r != 8'd0) c = c | BIT_RED;
        if (g != 8'd0) c = c | BIT_GREEN;
        if (b != 8'd0) c = c | BIT_BLUE;
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/led_matrix_row_scan_driver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix row scan driver
// One-bit-per-color frame store and row scanner for a 1/16 scan panel.
// ----------------------------------------------------------------------------
// A user issues a command by raising start while busy is low. A pixel write
// (func 0) is ignored when the pixel lies off the panel. A fill (func 1)
// sweeps the store of the 64x32 panel while busy is high, one address of each
// half memory per cycle. A refresh (func 2) reads one column per cycle from
// the two half memories while busy is high; each shift beat appears on the
// result ports for one cycle with strobe high, in the cycle after its read,
// so the last beat shows once busy has fallen. The receiver cannot stall
// these beats and must take one every cycle. The last beat of a refresh
// carries latch_last, after which the scan row moves on and wraps to zero
// after row 15. After reset the store is cleared by a pass over every
// address during which busy is high and no command is taken. Function
// code 3 is accepted and does nothing.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] func,
    input  wire logic [5:0] pixel_x,
    input  wire logic [4:0] pixel_y,
    input  wire logic [7:0] red_level,
    input  wire logic [7:0] green_level,
    input  wire logic [7:0] blue_level,
    output logic            strobe,
    output logic            top_red,
    output logic            top_green,
    output logic            top_blue,
    output logic            bottom_red,
    output logic            bottom_green,
    output logic            bottom_blue,
    output logic [3:0]      row_address,
    output logic [5:0]      column_index,
    output logic            latch_last
);
    import lmrsd_pkg::*;

    // Upper half (rows 0 .. HALF_HEIGHT-1) and lower half memories, both
    // addressed by column * HALF_HEIGHT + row within the half.
    logic [2:0] top_mem [HALF_DEPTH];
    logic [2:0] bot_mem [HALF_DEPTH];

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [2:0]        color_reg, color_next;

    // Beat registers that sit beside the registered memory read data.
    logic              strobe_reg, strobe_next;
    logic [COL_W-1:0]  col_out_reg;
    logic [ROW_W-1:0]  row_out_reg;
    logic              last_out_reg;
    logic [2:0]        top_rd_reg, bot_rd_reg;

    logic              accept;
    logic              sweep_end;
    logic              col_end;
    logic              row_wrap;
    logic              pix_in_panel;
    logic              pix_is_bot;
    logic [2:0]        pix_color;

    logic              we_top, we_bot;
    logic [ADDR_W-1:0] waddr;
    logic [2:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign sweep_end = (cnt_reg == ADDR_W'(HALF_DEPTH - 1));
    assign col_end   = (col_reg == COL_W'(PANEL_WIDTH - 1));
    assign row_wrap  = (int'(row_reg) == ROW_MAX) ||
                       (int'(row_reg) + 1 >= HALF_HEIGHT);
    assign pix_color = color_bits(red_level, green_level, blue_level);

    // Rows of an odd panel beyond both halves are never scanned, so a write
    // to them is dropped along with writes off the panel.
    assign pix_in_panel = (int'(pixel_x) < PANEL_WIDTH) &&
                          (int'(pixel_y) < 2 * HALF_HEIGHT);
    assign pix_is_bot   = (int'(pixel_y) >= HALF_HEIGHT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_end) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept) begin
                    if (func == FN_FILL) state_next = ST_FILL;
                    else if (func == FN_REFRESH) state_next = ST_SCAN;
                end
            end
            ST_FILL:
            begin
                if (sweep_end) state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (col_end) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory control and counters.
    always_comb
    begin
        we_top      = 1'b0;
        we_bot      = 1'b0;
        waddr       = cnt_reg;
        wdata       = color_reg;
        re          = 1'b0;
        raddr       = ADDR_W'(int'(col_reg) * HALF_HEIGHT + int'(row_reg));
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        color_next  = color_reg;
        strobe_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we_top   = 1'b1;
                we_bot   = 1'b1;
                wdata    = 3'b000;
                cnt_next = sweep_end ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                col_next = '0;
                if (accept) begin
                    if (func == FN_WRITE && pix_in_panel) begin
                        we_top = !pix_is_bot;
                        we_bot = pix_is_bot;
                        wdata  = pix_color;
                        waddr  = ADDR_W'(int'(pixel_x) * HALF_HEIGHT + int'(pixel_y)
                                         - (pix_is_bot ? HALF_HEIGHT : 0));
                    end
                    if (func == FN_FILL) color_next = pix_color;
                end
            end
            ST_FILL:
            begin
                we_top   = 1'b1;
                we_bot   = 1'b1;
                cnt_next = sweep_end ? '0 : cnt_reg + 1'b1;
            end
            ST_SCAN:
            begin
                re          = 1'b1;
                strobe_next = 1'b1;
                col_next    = col_end ? '0 : col_reg + 1'b1;
                if (col_end) row_next = row_wrap ? '0 : row_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            color_reg  <= 3'b000;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            color_reg  <= color_next;
            strobe_reg <= strobe_next;
        end
    end

    // Beat payload is registered with the read, like the memory data.
    always_ff @(posedge clk)
    begin
        if (re) begin
            col_out_reg  <= col_reg;
            row_out_reg  <= row_reg;
            last_out_reg <= col_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_top) top_mem[waddr] <= wdata;
        if (re) top_rd_reg <= top_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_bot) bot_mem[waddr] <= wdata;
        if (re) bot_rd_reg <= bot_mem[raddr];
    end

    assign strobe       = strobe_reg;
    assign top_red      = top_rd_reg[0];
    assign top_green    = top_rd_reg[1];
    assign top_blue     = top_rd_reg[2];
    assign bottom_red   = bot_rd_reg[0];
    assign bottom_green = bot_rd_reg[1];
    assign bottom_blue  = bot_rd_reg[2];
    assign row_address  = row_out_reg;
    assign column_index = 6'(col_out_reg);
    assign latch_last   = strobe_reg && last_out_reg;

    // A beat only follows a read issued by the scan.
    a_strobe_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_SCAN))
        else $error("shift beat without a scan read");

    // Beats of one refresh come back to back until the latch beat.
    a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !latch_last) |=> strobe)
        else $error("gap inside a refresh");

    // The latch beat belongs to the last column.
    a_latch_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        latch_last |-> (column_index == 6'(PANEL_WIDTH - 1)))
        else $error("latch on a column other than the last");

    // An accepted refresh holds off further commands.
    a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FN_REFRESH) |=> busy)
        else $error("refresh accepted but block not busy");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scan driver testbench
// Drives pixel writes, fills, refreshes and the unused function code with
// random gaps, models the frame store and the scan row, and checks every
// shift beat field by field against the modeled panel contents.
// ----------------------------------------------------------------------------

module tb;

    import lmrsd_pkg::*;

    // Function code 3 is accepted by the block and does nothing.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // Generous run limit: it covers a typical run with about a dozen fills, a
    // couple hundred refreshes and the idle gaps, and even a run of nothing but
    // fills behind the longest gaps, with a wide margin.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 400;

    // One command as it is presented on the input ports.
    typedef struct {
        logic [1:0] fn;
        logic [5:0] x;
        logic [4:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } panel_cmd_t;

    // One shift beat as it appears on the result ports.
    typedef struct {
        logic       t_red;
        logic       t_green;
        logic       t_blue;
        logic       b_red;
        logic       b_green;
        logic       b_blue;
        logic [3:0] row;
        logic [5:0] column;
        logic       latch;
    } shift_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a model of the frame store and scan row. Each accepted
    // refresh turns into one expected beat per column, and each beat that the
    // block emits is checked against the oldest of them.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [2:0]  pixels [PANEL_WIDTH * PANEL_HEIGHT];
        int          scan_row;
        shift_beat_t expected_beats [$];
        int          errors;

        function new();
            // The block clears its store after reset.
            foreach (pixels[i]) pixels[i] = 3'b000;
            scan_row = 0;
            errors   = 0;
        endfunction

        // Bit 0 is red, bit 1 green, bit 2 blue; any nonzero level is on.
        function logic [2:0] lamp_bits(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            return {b != 8'd0, g != 8'd0, r != 8'd0};
        endfunction

        function void note_command(panel_cmd_t c);
            logic [2:0]  color;
            logic [2:0]  upper;
            logic [2:0]  lower;
            shift_beat_t beat;
            color = lamp_bits(c.red, c.green, c.blue);
            if (c.fn == FN_WRITE) begin
                if (c.x < PANEL_WIDTH && c.y < PANEL_HEIGHT)
                    pixels[c.x * PANEL_HEIGHT + c.y] = color;
            end
            else if (c.fn == FN_FILL) begin
                foreach (pixels[i]) pixels[i] = color;
            end
            else if (c.fn == FN_REFRESH) begin
                for (int col = 0; col < PANEL_WIDTH; col++) begin
                    upper = pixels[col * PANEL_HEIGHT + scan_row];
                    lower = pixels[col * PANEL_HEIGHT + scan_row + HALF_HEIGHT];
                    beat.t_red   = upper[0];
                    beat.t_green = upper[1];
                    beat.t_blue  = upper[2];
                    beat.b_red   = lower[0];
                    beat.b_green = lower[1];
                    beat.b_blue  = lower[2];
                    beat.row     = scan_row[3:0];
                    beat.column  = col[5:0];
                    beat.latch   = (col == PANEL_WIDTH - 1);
                    expected_beats.push_back(beat);
                end
                scan_row++;
                if (scan_row >= HALF_HEIGHT || scan_row > ROW_MAX)
                    scan_row = 0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(shift_beat_t got);
            shift_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("shift beat with nothing expected: column %0d row %0d",
                       got.column, got.row);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("top_red",      want.t_red,   got.t_red);
            compare_field("top_green",    want.t_green, got.t_green);
            compare_field("top_blue",     want.t_blue,  got.t_blue);
            compare_field("bottom_red",   want.b_red,   got.b_red);
            compare_field("bottom_green", want.b_green, got.b_green);
            compare_field("bottom_blue",  want.b_blue,  got.b_blue);
            compare_field("row_address",  want.row,     got.row);
            compare_field("column_index", want.column,  got.column);
            compare_field("latch_last",   want.latch,   got.latch);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block connections
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] func;
    logic [5:0] pixel_x;
    logic [4:0] pixel_y;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       strobe;
    logic       top_red;
    logic       top_green;
    logic       top_blue;
    logic       bottom_red;
    logic       bottom_green;
    logic       bottom_blue;
    logic [3:0] row_address;
    logic [5:0] column_index;
    logic       latch_last;

    led_matrix_row_scan_driver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .strobe       (strobe),
        .top_red      (top_red),
        .top_green    (top_green),
        .top_blue     (top_blue),
        .bottom_red   (bottom_red),
        .bottom_green (bottom_green),
        .bottom_blue  (bottom_blue),
        .row_address  (row_address),
        .column_index (column_index),
        .latch_last   (latch_last)
    );

    frame_scoreboard sb;
    int              cycles = 0;
    int              burst_left;

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Watchdog: a hung handshake or a missing beat ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Beat monitor. The receiver cannot stall the block, so every strobe is
    // taken at the edge that ends its cycle and goes straight to the checker.
    always @(posedge clk)
    begin
        shift_beat_t got;
        if (rst_n === 1'b1 && strobe === 1'b1) begin
            got.t_red   = top_red;
            got.t_green = top_green;
            got.t_blue  = top_blue;
            got.b_red   = bottom_red;
            got.b_green = bottom_green;
            got.b_blue  = bottom_blue;
            got.row     = row_address;
            got.column  = column_index;
            got.latch   = latch_last;
            sb.check_beat(got);
        end
    end

    // ------------------------------------------------------------------------
    // Driving. Inputs change at the falling edge; a command is taken at the
    // rising edge where start is high and busy is low. Fields are held stable
    // while a command waits on busy.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input panel_cmd_t c);
        @(negedge clk);
        func        = c.fn;
        pixel_x     = c.x;
        pixel_y     = c.y;
        red_level   = c.red;
        green_level = c.green;
        blue_level  = c.blue;
        start       = 1'b1;
        // busy is read before this edge's updates land, so a low value here
        // means the command was taken at this edge.
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
    endtask

    // Drops start for a gap of length n and scribbles on the fields meanwhile;
    // the block must ignore all of it. With n of zero start stays high and the
    // next command follows back to back.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge clk);
            start       = 1'b0;
            func        = 2'($urandom);
            pixel_x     = 6'($urandom);
            pixel_y     = 5'($urandom);
            red_level   = 8'($urandom);
            green_level = 8'($urandom);
            blue_level  = 8'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Holds off until every expected beat has arrived.
    task automatic drain_beats();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly short gaps, now and then a long one, and stretches of
    // back-to-back commands so start also lands right as busy falls.
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        if (roll < 75)
            return $urandom_range(0, 2);
        if (roll < 95)
            return $urandom_range(3, 12);
        return $urandom_range(20, 90);
    endfunction

    // Levels lean on the edges: zero, full scale, a single bit, or anything.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'hFF;
            2:       return 8'(1 << $urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic panel_cmd_t make_cmd(logic [1:0] fn, int x, int y,
                                            int r, int g, int b);
        panel_cmd_t c;
        c.fn    = fn;
        c.x     = x[5:0];
        c.y     = y[4:0];
        c.red   = r[7:0];
        c.green = g[7:0];
        c.blue  = b[7:0];
        return c;
    endfunction

    // Random traffic is mostly pixel writes and refreshes, so each refresh
    // shows a frame built up by many writes; fills are rare because each one
    // holds the block for a full store sweep. A share of writes aims at the
    // two rows that the next refresh will shift, so fresh writes are seen
    // soon after they land.
    function automatic panel_cmd_t random_cmd();
        panel_cmd_t c;
        int         roll;
        c.x     = 6'($urandom);
        c.y     = 5'($urandom);
        c.red   = pick_level();
        c.green = pick_level();
        c.blue  = pick_level();
        roll    = $urandom_range(0, 99);
        if (roll < 3)
            c.fn = FN_FILL;
        else if (roll < 55) begin
            c.fn = FN_WRITE;
            if ($urandom_range(0, 2) == 0)
                c.y = 5'(sb.scan_row + ($urandom_range(0, 1) ? HALF_HEIGHT : 0));
        end
        else if (roll < 93)
            c.fn = FN_REFRESH;
        else
            c.fn = FN_UNUSED;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        panel_cmd_t directed [$];

        sb          = new();
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FN_WRITE;
        pixel_x     = '0;
        pixel_y     = '0;
        red_level   = '0;
        green_level = '0;
        blue_level  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first refresh reads the store that the clearing
        // pass left behind. Row 1 then gets pixels at both panel edges and in
        // both halves with single-channel and full-scale levels, and a write
        // of all-zero levels turns a pixel off. The unused function code
        // carries live fields and must leave the store alone. A fill with a
        // mix of minimum nonzero, mid and full-scale levels lights every channel, and a
        // fill of zeros clears the panel again. The corner pixels written at
        // the end are seen once the scan row wraps around to them.
        directed.push_back(make_cmd(FN_REFRESH, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_WRITE, 0, 1, 1, 0, 0));
        directed.push_back(make_cmd(FN_WRITE, 0, 17, 0, 255, 0));
        directed.push_back(make_cmd(FN_WRITE, 63, 1, 0, 0, 128));
        directed.push_back(make_cmd(FN_WRITE, 63, 17, 255, 255, 255));
        directed.push_back(make_cmd(FN_WRITE, 31, 1, 255, 255, 255));
        directed.push_back(make_cmd(FN_WRITE, 31, 1, 0, 0, 0));
        directed.push_back(make_cmd(FN_WRITE, 32, 17, 2, 64, 0));
        directed.push_back(make_cmd(FN_REFRESH, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_UNUSED, 5, 2, 255, 255, 255));
        directed.push_back(make_cmd(FN_UNUSED, 63, 31, 255, 255, 255));
        directed.push_back(make_cmd(FN_REFRESH, 63, 31, 255, 255, 255));
        directed.push_back(make_cmd(FN_FILL, 63, 31, 1, 128, 255));
        directed.push_back(make_cmd(FN_WRITE, 10, 4, 0, 0, 0));
        directed.push_back(make_cmd(FN_WRITE, 11, 20, 0, 7, 0));
        directed.push_back(make_cmd(FN_REFRESH, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_REFRESH, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_FILL, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_REFRESH, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FN_WRITE, 63, 31, 255, 255, 255));
        directed.push_back(make_cmd(FN_WRITE, 0, 15, 255, 0, 255));
        directed.push_back(make_cmd(FN_WRITE, 63, 15, 0, 1, 0));

        foreach (directed[i]) begin
            send_cmd(directed[i]);
            idle_cycles(pick_gap());
        end

        // Let the directed frames drain before the random traffic starts.
        drain_beats();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_cmd(random_cmd());
            if (n == RANDOM_ITEMS / 2)
                drain_beats();
            else
                idle_cycles(pick_gap());
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Give a stray beat time to show up: one refresh is 64 beats.
        repeat (PANEL_WIDTH + 16) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
